// ===== sv/ith_pkg.sv =====
// Shared types, widths and codes of the iterative histogram threshold block.
package ith_pkg;

    localparam int MAX_PIXELS_LOG2 = 20;
    localparam int FRAC_BITS       = 8;
    localparam int NUM_BINS        = 256;
    localparam int LVL_W           = 8;
    localparam int CNT_W           = MAX_PIXELS_LOG2 + 1;
    localparam int SUM_W           = CNT_W + LVL_W;
    localparam int T_W             = LVL_W + FRAC_BITS;
    localparam int DVD_W           = SUM_W + FRAC_BITS;
    localparam int DIV_CNT_W       = $clog2(DVD_W + 1);
    localparam int FIFO_DEPTH      = 4;
    localparam int PTR_W           = $clog2(FIFO_DEPTH);
    localparam int FILL_W          = $clog2(FIFO_DEPTH + 1);

    localparam logic [LVL_W-1:0] WHITE        = 8'd255;
    localparam logic [LVL_W-1:0] BLACK        = 8'd0;
    localparam logic [LVL_W-1:0] LAST_BIN     = 8'd255;
    localparam logic [7:0]       MAX_ITER_RST = 8'd64;

    localparam logic KIND_HIST = 1'b0;
    localparam logic KIND_BIN  = 1'b1;
    localparam logic RES_THR   = 1'b0;
    localparam logic RES_PIX   = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [LVL_W-1:0] pixel;
        logic             last;
    } t_in_item;

    typedef struct packed {
        logic             result_kind;
        logic [LVL_W-1:0] value;
        logic             converged;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic           done;
        logic [T_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== sv/ith_ram.sv =====
// Generic single-port RAM with registered read.
module ith_ram #(
    parameter int W = 8,
    parameter int D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_addr,
    input  logic [W-1:0]         i_wdata,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/ith_div.sv =====
// Restoring divider, one quotient bit per cycle.
module ith_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ith_pkg::t_div_req i_req,
    output ith_pkg::t_div_rsp o_rsp
);
    logic                            r_busy;
    logic                            r_done;
    logic [ith_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [ith_pkg::CNT_W-1:0]       r_rem;
    logic [ith_pkg::DVD_W-1:0]       r_dvd;
    logic [ith_pkg::CNT_W-1:0]       r_dsr;
    logic [ith_pkg::T_W-1:0]         r_quo;
    logic [ith_pkg::CNT_W:0]         shifted;
    logic                            fits;

    assign shifted = {r_rem, r_dvd[ith_pkg::DVD_W-1]};
    assign fits    = shifted >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= ith_pkg::DIV_CNT_W'(ith_pkg::DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ith_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
            r_dsr <= i_req.divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[ith_pkg::DVD_W-2:0], 1'b0};
            r_quo <= {r_quo[ith_pkg::T_W-2:0], fits};
            // remainder stays below the divisor, so it fits back in CNT_W bits
            r_rem <= fits ? ith_pkg::CNT_W'(shifted - {1'b0, r_dsr})
                          : shifted[ith_pkg::CNT_W-1:0];
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule

// ===== sv/ith_front.sv =====
// Front: input request queue that decouples the pixel source from the back end.
module ith_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    input  ith_pkg::t_in_item i_in,
    output logic              full,
    input  logic              i_hold,
    output logic              o_vld,
    output ith_pkg::t_in_item o_item,
    input  logic              i_take
);
    ith_pkg::t_in_item               r_mem [ith_pkg::FIFO_DEPTH];
    logic [ith_pkg::PTR_W-1:0]       r_wp;
    logic [ith_pkg::PTR_W-1:0]       r_rp;
    logic [ith_pkg::FILL_W-1:0]      r_fill;
    logic                            wr;
    logic                            rd;

    assign full   = (r_fill == ith_pkg::FILL_W'(ith_pkg::FIFO_DEPTH)) || i_hold;
    assign wr     = push && !full;
    assign o_vld  = r_fill != '0;
    assign rd     = i_take && o_vld;
    assign o_item = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (wr && !rd) begin
                r_fill <= r_fill + 1'b1;
            end else if (rd && !wr) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_in;
        end
    end
endmodule

// ===== sv/ith_back.sv =====
// Back: histogram update, isodata threshold search, binarize and result register.
module ith_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  ith_pkg::t_in_item  i_item,
    output logic               o_take,
    output logic               o_init,
    input  logic [7:0]         i_max_iter,
    output logic               empty,
    input  logic               pop,
    output ith_pkg::t_out_item o_out
);
    typedef enum logic [11:0] {
        S_CLEAR     = 12'b000000000001,
        S_IDLE      = 12'b000000000010,
        S_INC       = 12'b000000000100,
        S_MEAN      = 12'b000000001000,
        S_WAIT_MEAN = 12'b000000010000,
        S_ROUND     = 12'b000000100000,
        S_SWEEP     = 12'b000001000000,
        S_DRAIN     = 12'b000010000000,
        S_SPLIT     = 12'b000100000000,
        S_WAIT_LO   = 12'b001000000000,
        S_WAIT_HI   = 12'b010000000000,
        S_FINISH    = 12'b100000000000
    } t_state;

    t_state                         r_state;
    logic                           r_init;
    logic [ith_pkg::LVL_W-1:0]      r_idx;
    logic [ith_pkg::LVL_W-1:0]      r_pix;
    logic                           r_last;
    logic [ith_pkg::CNT_W-1:0]      r_count;
    logic [ith_pkg::SUM_W-1:0]      r_sum;
    logic [ith_pkg::LVL_W-1:0]      r_thr;
    logic [ith_pkg::T_W-1:0]        r_t;
    logic [ith_pkg::T_W-1:0]        r_mlo;
    logic [7:0]                     r_round;
    logic                           r_conv;
    logic                           r_rd_vld;
    logic [ith_pkg::LVL_W-1:0]      r_rd_lvl;
    logic [ith_pkg::CNT_W-1:0]      r_cnt_lo;
    logic [ith_pkg::CNT_W-1:0]      r_cnt_hi;
    logic [ith_pkg::SUM_W-1:0]      r_sum_lo;
    logic [ith_pkg::SUM_W-1:0]      r_sum_hi;
    logic                           r_out_vld;
    ith_pkg::t_out_item             r_out;

    logic                           ram_we;
    logic [ith_pkg::LVL_W-1:0]      ram_addr;
    logic [ith_pkg::CNT_W-1:0]      ram_wdata;
    logic [ith_pkg::CNT_W-1:0]      ram_rdata;
    ith_pkg::t_div_req              div_req;
    ith_pkg::t_div_rsp              div_rsp;
    logic                           out_free;
    logic [ith_pkg::SUM_W-1:0]      prod;
    logic [ith_pkg::T_W-1:0]        lvl_fx;
    logic [ith_pkg::T_W:0]          pair;
    logic [ith_pkg::T_W-1:0]        nxt;

    ith_ram #(.W(ith_pkg::CNT_W), .D(ith_pkg::NUM_BINS)) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    ith_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign out_free = !r_out_vld || pop;
    assign o_take   = (r_state == S_IDLE) && i_vld
                      && (i_item.kind == ith_pkg::KIND_HIST || out_free);
    assign o_init   = r_init;
    assign empty    = !r_out_vld;
    assign o_out    = r_out;

    assign prod   = ith_pkg::SUM_W'(ram_rdata) * ith_pkg::SUM_W'(r_rd_lvl);
    assign lvl_fx = {r_rd_lvl, {ith_pkg::FRAC_BITS{1'b0}}};
    assign pair   = {1'b0, r_mlo} + {1'b0, div_rsp.quotient};
    assign nxt    = pair[ith_pkg::T_W:1];

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_idx;
        ram_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
            end
            S_IDLE: begin
                ram_addr = i_item.pixel;
            end
            S_INC: begin
                ram_we    = 1'b1;
                ram_addr  = r_pix;
                ram_wdata = ram_rdata + 1'b1;
            end
            default: begin
                ram_addr = r_idx;
            end
        endcase
    end

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = {r_sum, {ith_pkg::FRAC_BITS{1'b0}}};
        div_req.divisor  = r_count;
        unique case (r_state)
            S_MEAN: begin
                div_req.start = r_count != '0;
            end
            S_SPLIT: begin
                div_req.start    = (r_cnt_lo != '0) && (r_cnt_hi != '0);
                div_req.dividend = {r_sum_lo, {ith_pkg::FRAC_BITS{1'b0}}};
                div_req.divisor  = r_cnt_lo;
            end
            S_WAIT_LO: begin
                div_req.start    = div_rsp.done;
                div_req.dividend = {r_sum_hi, {ith_pkg::FRAC_BITS{1'b0}}};
                div_req.divisor  = r_cnt_hi;
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_init    <= 1'b1;
            r_idx     <= '0;
            r_count   <= '0;
            r_sum     <= '0;
            r_thr     <= '0;
            r_out_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_rd_vld <= 1'b0;
            if (pop && r_out_vld) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == ith_pkg::LAST_BIN) begin
                        r_init  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_take) begin
                        if (i_item.kind == ith_pkg::KIND_BIN) begin
                            r_out_vld <= 1'b1;
                        end else if (!r_count[ith_pkg::MAX_PIXELS_LOG2]) begin
                            r_state <= S_INC;
                        end else if (i_item.last) begin
                            // drop the pixel, still run the search
                            r_state <= S_MEAN;
                        end
                    end
                end
                S_INC: begin
                    r_count <= r_count + 1'b1;
                    r_sum   <= r_sum + ith_pkg::SUM_W'(r_pix);
                    r_state <= r_last ? S_MEAN : S_IDLE;
                end
                S_MEAN: begin
                    r_state <= (r_count == '0) ? S_ROUND : S_WAIT_MEAN;
                end
                S_WAIT_MEAN: begin
                    if (div_rsp.done) begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_idx   <= '0;
                    r_state <= (r_round >= i_max_iter) ? S_FINISH : S_SWEEP;
                end
                S_SWEEP: begin
                    r_idx    <= r_idx + 1'b1;
                    r_rd_vld <= 1'b1;
                    if (r_idx == ith_pkg::LAST_BIN) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_SPLIT;
                end
                S_SPLIT: begin
                    r_state <= div_req.start ? S_WAIT_LO : S_FINISH;
                end
                S_WAIT_LO: begin
                    if (div_rsp.done) begin
                        r_state <= S_WAIT_HI;
                    end
                end
                S_WAIT_HI: begin
                    if (div_rsp.done) begin
                        r_state <= (nxt == r_t) ? S_FINISH : S_ROUND;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out_vld <= 1'b1;
                        r_thr     <= r_t[ith_pkg::T_W-1:ith_pkg::FRAC_BITS];
                        r_count   <= '0;
                        r_sum     <= '0;
                        r_idx     <= '0;
                        r_state   <= S_CLEAR;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_rd_lvl <= r_idx;
        if (r_state == S_IDLE && o_take) begin
            r_pix  <= i_item.pixel;
            r_last <= i_item.last;
            if (i_item.kind == ith_pkg::KIND_BIN) begin
                r_out.result_kind <= ith_pkg::RES_PIX;
                r_out.value       <= (i_item.pixel < r_thr) ? ith_pkg::BLACK : ith_pkg::WHITE;
                r_out.converged   <= 1'b0;
            end
        end
        if (r_state == S_MEAN) begin
            r_t     <= '0;
            r_round <= '0;
            r_conv  <= 1'b0;
        end
        if (r_state == S_WAIT_MEAN && div_rsp.done) begin
            r_t <= div_rsp.quotient;
        end
        if (r_state == S_ROUND) begin
            r_cnt_lo <= '0;
            r_cnt_hi <= '0;
            r_sum_lo <= '0;
            r_sum_hi <= '0;
        end
        if (r_rd_vld) begin
            if (lvl_fx < r_t) begin
                r_cnt_lo <= r_cnt_lo + ram_rdata;
                r_sum_lo <= r_sum_lo + prod;
            end else begin
                r_cnt_hi <= r_cnt_hi + ram_rdata;
                r_sum_hi <= r_sum_hi + prod;
            end
        end
        if (r_state == S_WAIT_LO && div_rsp.done) begin
            r_mlo <= div_rsp.quotient;
        end
        if (r_state == S_WAIT_HI && div_rsp.done) begin
            if (nxt == r_t) begin
                r_conv <= 1'b1;
            end else begin
                r_t     <= nxt;
                r_round <= r_round + 1'b1;
            end
        end
        if (r_state == S_FINISH && out_free) begin
            r_out.result_kind <= ith_pkg::RES_THR;
            r_out.value       <= r_t[ith_pkg::T_W-1:ith_pkg::FRAC_BITS];
            r_out.converged   <= r_conv;
        end
    end
endmodule

// ===== sv/iterative_histogram_threshold.sv =====
// Top level of the iterative histogram threshold block.
//
//  channel   handshake                  payload
//  input     push / full                i_in  (kind, pixel, last)
//  result    empty / pop                o_out (result_kind, value, converged)
//  config    i_cfg_valid / o_cfg_ready  i_cfg_data (max_iterations)
//
// A binarize pixel is handled in the idle state alone, a histogram pixel needs a read, then
// an increment and write of the single-port bin RAM. The search after the last pixel takes a
// mean division, then per round a sweep of all 256 bins plus two divisions in the shared
// divider, then a clear of all 256 bins. After reset full stays high during the clear of the
// bin RAM. A four-entry request queue absorbs input while the back end works; a held result
// stalls only the items that produce results.
module iterative_histogram_threshold (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  ith_pkg::t_in_item  i_in,
    output logic               full,
    output logic               empty,
    input  logic               pop,
    output ith_pkg::t_out_item o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_data
);
    logic              r_max_iter;
    logic [7:0]        r_max_iter_q;
    logic              q_vld;
    logic              q_take;
    logic              init;
    ith_pkg::t_in_item q_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter_q <= ith_pkg::MAX_ITER_RST;
            r_max_iter   <= 1'b0;
        end else begin
            r_max_iter <= i_cfg_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_iter_q <= i_cfg_data;
            end
        end
    end

    ith_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .i_in    (i_in),
        .full    (full),
        .i_hold  (init || r_max_iter),
        .o_vld   (q_vld),
        .o_item  (q_item),
        .i_take  (q_take)
    );

    ith_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (q_vld),
        .i_item     (q_item),
        .o_take     (q_take),
        .o_init     (init),
        .i_max_iter (r_max_iter_q),
        .empty      (empty),
        .pop        (pop),
        .o_out      (o_out)
    );
endmodule

// ===== sv/ith_checker.sv =====
// Port-level checker for the iterative histogram threshold block, with its bind.
module ith_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               push,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input ith_pkg::t_out_item o_out
);
    // reset empties the result side and holds off input during the bin clear
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && full)
        else $error("result or input side not idle after reset");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out))
        else $error("waiting result changed before pop");

    a_binary_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_out.result_kind == ith_pkg::RES_PIX |->
            (o_out.value == ith_pkg::BLACK || o_out.value == ith_pkg::WHITE)
            && !o_out.converged)
        else $error("binarized pixel is not black or white");

    a_push_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) && i_rst_n |-> full)
        else $error("input accepted during reset bin clear");
endmodule

bind iterative_histogram_threshold ith_checker u_ith_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .push    (push),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_out   (o_out)
);
